// ===== src/rsn_pkg.sv =====
// Shared constants, codes and types of the resource string to number converter.
`default_nettype none

package rsn_pkg;

   localparam int CHAR_W    = 8;
   localparam int VALUE_W   = 64;
   localparam int CSR_IDX_W = 3;
   localparam int MEGA_W    = 21;
   localparam int GIGA_W    = 31;
   localparam int TERA_W    = 41;
   localparam int KDIV_W    = 21;
   localparam int WORD_W    = 7;
   localparam int MUL_W     = TERA_W;
   localparam int P2_W      = 12;
   localparam int CNT_W     = $clog2(VALUE_W);
   localparam int FSC_W     = 2 * CHAR_W;

   localparam logic [MEGA_W-1:0]  MEGA_RST   = 21'd1024;
   localparam logic [GIGA_W-1:0]  GIGA_RST   = 31'd1048576;
   localparam logic [TERA_W-1:0]  TERA_RST   = 41'd1073741824;
   localparam logic [KDIV_W-1:0]  KDIV_RST   = 21'd1024;
   localparam logic [WORD_W-1:0]  WORD_RST   = 7'd8;
   localparam logic [VALUE_W-1:0] UNSPEC_RST = {VALUE_W{1'b1}};

   localparam logic [WORD_W-1:0] WORD_ONE = 7'd1;
   localparam logic [KDIV_W-1:0] KDIV_ONE = 21'd1;
   localparam logic [P2_W-1:0]   P2_ONE   = 12'd1;

   localparam logic [P2_W-1:0] SECS_PER_HOUR = 12'd3600;
   localparam logic [P2_W-1:0] SECS_PER_MIN  = 12'd60;

   localparam logic [VALUE_W-1:0] MAG_LIMIT = 64'h8000_0000_0000_0000;
   localparam logic [VALUE_W-1:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [VALUE_W-1:0] MAG_TENTH = 64'd922337203685477580;

   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
   localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
   localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
   localparam logic [CHAR_W-1:0] CH_UB    = 8'h42;
   localparam logic [CHAR_W-1:0] CH_UG    = 8'h47;
   localparam logic [CHAR_W-1:0] CH_UM    = 8'h4D;
   localparam logic [CHAR_W-1:0] CH_UT    = 8'h54;
   localparam logic [CHAR_W-1:0] CH_LB    = 8'h62;
   localparam logic [CHAR_W-1:0] CH_LG    = 8'h67;
   localparam logic [CHAR_W-1:0] CH_LM    = 8'h6D;
   localparam logic [CHAR_W-1:0] CH_LT    = 8'h74;
   localparam logic [CHAR_W-1:0] CH_LW    = 8'h77;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MEGA_TO_KILO      = 3'd0,
      REG_GIGA_TO_KILO      = 3'd1,
      REG_TERA_TO_KILO      = 3'd2,
      REG_KILO_DIVISOR      = 3'd3,
      REG_WORD_SIZE         = 3'd4,
      REG_UNSPECIFIED_VALUE = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_NEG,
      ALU_DEC
   } alu_op_type;

   typedef struct packed {
      alu_op_type         op;
      logic [VALUE_W-1:0] a;
      logic [VALUE_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] sum;
      logic               carry;
   } alu_rsp_type;

endpackage

`default_nettype wire

// ===== src/rsn_ifs.sv =====
// Valid/ready channel interfaces for character input, result output and register writes.
`default_nettype none

interface rsn_req_if;
   logic                       valid;
   logic                       ready;
   logic [rsn_pkg::CHAR_W-1:0] character;
   logic                       last;
   modport source (output valid, output character, output last, input ready);
   modport sink (input valid, input character, input last, output ready);
endinterface

interface rsn_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [rsn_pkg::VALUE_W-1:0] value;
   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface rsn_csr_if;
   logic                          valid;
   logic                          ready;
   logic [rsn_pkg::CSR_IDX_W-1:0] index;
   logic [rsn_pkg::VALUE_W-1:0]   data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/rsn_alu.sv =====
// Shared 64-bit three-operand adder: add, subtract with carry, negate, times ten plus digit.
`default_nettype none

module rsn_alu (
   input  rsn_pkg::alu_req_type req,
   output rsn_pkg::alu_rsp_type rsp
);

   logic [rsn_pkg::VALUE_W:0] op_a;
   logic [rsn_pkg::VALUE_W:0] op_b;
   logic [rsn_pkg::VALUE_W:0] op_c;
   logic [rsn_pkg::VALUE_W:0] total;

   always_comb begin
      case (req.op)
         rsn_pkg::ALU_ADD: begin
            op_a = {1'b0, req.a};
            op_b = {1'b0, req.b};
            op_c = '0;
         end
         rsn_pkg::ALU_SUB: begin
            // carry out set means a >= b
            op_a = {1'b0, req.a};
            op_b = {1'b0, ~req.b};
            op_c = {{rsn_pkg::VALUE_W{1'b0}}, 1'b1};
         end
         rsn_pkg::ALU_NEG: begin
            op_a = {1'b0, ~req.a};
            op_b = '0;
            op_c = {{rsn_pkg::VALUE_W{1'b0}}, 1'b1};
         end
         rsn_pkg::ALU_DEC: begin
            // a*8 + a*2 + digit
            op_a = {1'b0, req.a[rsn_pkg::VALUE_W-4:0], 3'b000};
            op_b = {1'b0, req.a[rsn_pkg::VALUE_W-2:0], 1'b0};
            op_c = {1'b0, req.b};
         end
         default: begin
            op_a = '0;
            op_b = '0;
            op_c = '0;
         end
      endcase
      total = op_a + op_b + op_c;
   end

   assign rsp.sum   = total[rsn_pkg::VALUE_W-1:0];
   assign rsp.carry = total[rsn_pkg::VALUE_W];

endmodule

`default_nettype wire

// ===== src/resource_string_to_number_core.sv =====
// Top level of the resource string to number converter: character parser and arithmetic sequencer.
//
// Characters of a resource string enter one per transfer on req_ch, the final one flagged by
// last; one signed 64-bit value leaves on rsp_ch per string. Each character is taken in its
// transfer cycle and then parsed in S_STEP, so ready drops after every transfer. Where the
// string ends or the suffix is known, a further parse step (S_END) may follow and then
// arithmetic on the single shared 64-bit adder: a multiply runs one multiplier bit per cycle
// in two passes, the b, B and w suffixes add a restoring division by kilo_divisor, and the
// result register is loaded in S_OUT. The result register frees the input side, so the next
// string may start while a value waits on rsp_ch. Registers on csr_ch are always ready.
`default_nettype none

module resource_string_to_number_core (
   input  logic           clock,
   input  logic           reset,
   rsn_req_if.sink        req_ch,
   rsn_rsp_if.source      rsp_ch,
   rsn_csr_if.sink        csr_ch
);

   typedef enum logic [2:0] {
      PH_FIRST,
      PH_SUFFIX_NEXT,
      PH_SECOND,
      PH_THIRD,
      PH_TRAIL_NEXT,
      PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_STEP,
      S_END,
      S_DNEG,
      S_DIV,
      S_DFIX,
      S_MUL,
      S_OUT
   } state_type;

   state_type phase_dummy_unused_guard;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   logic                               sign_ff, sign_in;
   logic                               digits_ff, digits_in;
   logic                               open_ff, open_in;
   logic [1:0]                         field_len_ff, field_len_in;
   logic [rsn_pkg::FSC_W-1:0]          fsc_ff, fsc_in;
   logic [rsn_pkg::VALUE_W-1:0]        mag_ff, mag_in;
   logic [rsn_pkg::VALUE_W-1:0]        lead_ff, lead_in;
   logic [rsn_pkg::VALUE_W-1:0]        mid_ff, mid_in;
   logic [rsn_pkg::CHAR_W-1:0]         stop_ff, stop_in;
   logic [rsn_pkg::CHAR_W-1:0]         char_ff, char_in;
   logic                               last_ff, last_in;

   logic [rsn_pkg::VALUE_W-1:0]        acc_ff, acc_in;
   logic [rsn_pkg::VALUE_W-1:0]        x_ff, x_in;
   logic [rsn_pkg::MUL_W-1:0]          y_ff, y_in;
   logic [rsn_pkg::P2_W-1:0]           p2_y_ff, p2_y_in;
   logic                               p2_chain_ff, p2_chain_in;
   logic                               pass_ff, pass_in;
   logic                               neg_ff, neg_in;
   logic [rsn_pkg::KDIV_W-1:0]         rem_ff, rem_in;
   logic [rsn_pkg::CNT_W-1:0]          cnt_ff, cnt_in;

   logic                               out_valid_ff, out_valid_in;
   logic [rsn_pkg::VALUE_W-1:0]        out_value_ff, out_value_in;

   logic [rsn_pkg::MEGA_W-1:0]         mega_ff, mega_in;
   logic [rsn_pkg::GIGA_W-1:0]         giga_ff, giga_in;
   logic [rsn_pkg::TERA_W-1:0]         tera_ff, tera_in;
   logic [rsn_pkg::KDIV_W-1:0]         kdiv_ff, kdiv_in;
   logic [rsn_pkg::WORD_W-1:0]         word_ff, word_in;
   logic [rsn_pkg::VALUE_W-1:0]        unspec_ff, unspec_in;

   rsn_pkg::alu_req_type               alu_req;
   rsn_pkg::alu_rsp_type               alu_rsp;

   logic [rsn_pkg::CHAR_W-1:0]         ec;
   logic                               is_digit;
   logic                               is_blank;
   logic                               is_sign;
   logic                               scan_ok;
   logic [rsn_pkg::VALUE_W-1:0]        dig_mag;
   logic [rsn_pkg::VALUE_W-1:0]        fin;
   logic [rsn_pkg::CHAR_W-1:0]         first;
   logic [rsn_pkg::CHAR_W-1:0]         stop_pt;
   logic [rsn_pkg::CHAR_W-1:0]         after_ch;
   logic [rsn_pkg::KDIV_W-1:0]         kdiv_eff;
   logic [rsn_pkg::KDIV_W:0]           rem_shift;
   logic [rsn_pkg::MUL_W-1:0]          m1;
   logic [rsn_pkg::WORD_W-1:0]         m2;
   logic                               suffix_div;
   logic                               job_go;
   logic                               job_div;
   logic                               field_clear;
   logic                               string_clear;

   function automatic logic [rsn_pkg::WORD_W-1:0] wmul(
      input logic [rsn_pkg::CHAR_W-1:0] ch,
      input logic [rsn_pkg::WORD_W-1:0] word
   );
      wmul = (ch == rsn_pkg::CH_LW) ? word : rsn_pkg::WORD_ONE;
   endfunction

   assign phase_dummy_unused_guard = state_ff;

   rsn_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.value = out_value_ff;

   // character classes and number finishing
   always_comb begin
      ec        = (state_ff == S_END) ? rsn_pkg::CH_NUL : char_ff;
      is_digit  = ec inside {[rsn_pkg::CH_0:rsn_pkg::CH_9]};
      is_blank  = ec inside {rsn_pkg::CH_SPACE, [rsn_pkg::CH_TAB:rsn_pkg::CH_CR]};
      is_sign   = ec inside {rsn_pkg::CH_PLUS, rsn_pkg::CH_MINUS};
      scan_ok   = is_digit || (!open_ff && (is_blank || is_sign));
      first     = (field_len_ff != 2'd0) ? fsc_ff[rsn_pkg::CHAR_W-1:0] : ec;
      stop_pt   = digits_ff ? ec : first;
      after_ch  = (field_len_ff == 2'd1) ? ec : fsc_ff[rsn_pkg::FSC_W-1:rsn_pkg::CHAR_W];
      kdiv_eff  = (kdiv_ff == '0) ? rsn_pkg::KDIV_ONE : kdiv_ff;
      rem_shift = {rem_ff, x_ff[rsn_pkg::VALUE_W-1]};

      if (mag_ff > rsn_pkg::MAG_TENTH || alu_rsp.sum > rsn_pkg::MAG_LIMIT) begin
         dig_mag = rsn_pkg::MAG_LIMIT;
      end else begin
         dig_mag = alu_rsp.sum;
      end

      if (!digits_ff) begin
         fin = '0;
      end else if (sign_ff) begin
         fin = alu_rsp.sum;
      end else if (mag_ff > rsn_pkg::POS_LIMIT) begin
         fin = rsn_pkg::POS_LIMIT;
      end else begin
         fin = mag_ff;
      end

      suffix_div = stop_ff inside {rsn_pkg::CH_LB, rsn_pkg::CH_UB, rsn_pkg::CH_LW};
      if (stop_ff inside {rsn_pkg::CH_LM, rsn_pkg::CH_UM}) begin
         m1 = {{(rsn_pkg::MUL_W-rsn_pkg::MEGA_W){1'b0}}, mega_ff};
      end else if (stop_ff inside {rsn_pkg::CH_LG, rsn_pkg::CH_UG}) begin
         m1 = {{(rsn_pkg::MUL_W-rsn_pkg::GIGA_W){1'b0}}, giga_ff};
      end else if (stop_ff inside {rsn_pkg::CH_LT, rsn_pkg::CH_UT}) begin
         m1 = tera_ff;
      end else if (stop_ff == rsn_pkg::CH_LW) begin
         m1 = {{(rsn_pkg::MUL_W-rsn_pkg::WORD_W){1'b0}}, word_ff};
      end else begin
         m1 = {{(rsn_pkg::MUL_W-1){1'b0}}, 1'b1};
      end
      m2 = (stop_ff != rsn_pkg::CH_NUL) ? wmul(ec, word_ff) : rsn_pkg::WORD_ONE;
   end

   // shared adder operand selection
   always_comb begin
      case (state_ff)
         S_STEP, S_END: begin
            alu_req.op = is_digit ? rsn_pkg::ALU_DEC : rsn_pkg::ALU_NEG;
            alu_req.a  = mag_ff;
            alu_req.b  = {{(rsn_pkg::VALUE_W-4){1'b0}}, ec[3:0]};
         end
         S_DNEG, S_DFIX: begin
            alu_req.op = rsn_pkg::ALU_NEG;
            alu_req.a  = x_ff;
            alu_req.b  = '0;
         end
         S_DIV: begin
            alu_req.op = rsn_pkg::ALU_SUB;
            alu_req.a  = {{(rsn_pkg::VALUE_W-rsn_pkg::KDIV_W-1){1'b0}}, rem_shift};
            alu_req.b  = {{(rsn_pkg::VALUE_W-rsn_pkg::KDIV_W){1'b0}}, kdiv_eff};
         end
         default: begin
            alu_req.op = rsn_pkg::ALU_ADD;
            alu_req.a  = acc_ff;
            alu_req.b  = x_ff;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      sign_in      = sign_ff;
      digits_in    = digits_ff;
      open_in      = open_ff;
      field_len_in = field_len_ff;
      fsc_in       = fsc_ff;
      mag_in       = mag_ff;
      lead_in      = lead_ff;
      mid_in       = mid_ff;
      stop_in      = stop_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      acc_in       = acc_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      p2_y_in      = p2_y_ff;
      p2_chain_in  = p2_chain_ff;
      pass_in      = pass_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      mega_in      = mega_ff;
      giga_in      = giga_ff;
      tera_in      = tera_ff;
      kdiv_in      = kdiv_ff;
      word_in      = word_ff;
      unspec_in    = unspec_ff;
      job_go       = 1'b0;
      job_div      = 1'b0;
      field_clear  = 1'b0;
      string_clear = 1'b0;

      if (csr_ch.valid) begin
         case (csr_ch.index)
            rsn_pkg::REG_MEGA_TO_KILO:      mega_in   = csr_ch.data[rsn_pkg::MEGA_W-1:0];
            rsn_pkg::REG_GIGA_TO_KILO:      giga_in   = csr_ch.data[rsn_pkg::GIGA_W-1:0];
            rsn_pkg::REG_TERA_TO_KILO:      tera_in   = csr_ch.data[rsn_pkg::TERA_W-1:0];
            rsn_pkg::REG_KILO_DIVISOR:      kdiv_in   = csr_ch.data[rsn_pkg::KDIV_W-1:0];
            rsn_pkg::REG_WORD_SIZE:         word_in   = csr_ch.data[rsn_pkg::WORD_W-1:0];
            rsn_pkg::REG_UNSPECIFIED_VALUE: unspec_in = csr_ch.data;
            default: ;
         endcase
      end

      if (out_valid_ff && rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               char_in  = req_ch.character;
               last_in  = req_ch.last;
               state_in = S_STEP;
            end
         end

         S_STEP, S_END: begin
            case (phase_ff)
               PH_FIRST, PH_SECOND, PH_THIRD: begin
                  if (scan_ok) begin
                     if (is_digit) begin
                        open_in   = 1'b1;
                        digits_in = 1'b1;
                        mag_in    = dig_mag;
                     end else if (is_sign) begin
                        sign_in = (ec == rsn_pkg::CH_MINUS);
                        open_in = 1'b1;
                     end
                     if (field_len_ff == 2'd0) begin
                        fsc_in = {{rsn_pkg::CHAR_W{1'b0}}, ec};
                     end else if (field_len_ff == 2'd1) begin
                        fsc_in = {ec, fsc_ff[rsn_pkg::CHAR_W-1:0]};
                     end
                     if (field_len_ff != 2'd2) begin
                        field_len_in = field_len_ff + 2'd1;
                     end
                  end else if (phase_ff == PH_FIRST) begin
                     lead_in = fin;
                     if (ec == rsn_pkg::CH_NUL) begin
                        phase_in = PH_DONE;
                     end else begin
                        stop_in = stop_pt;
                        if (stop_pt == rsn_pkg::CH_COLON) begin
                           field_clear = 1'b1;
                           phase_in    = PH_SECOND;
                        end else begin
                           phase_in = PH_SUFFIX_NEXT;
                        end
                     end
                  end else if (phase_ff == PH_SECOND) begin
                     mid_in = fin;
                     if (stop_pt == rsn_pkg::CH_COLON) begin
                        field_clear = 1'b1;
                        phase_in    = PH_THIRD;
                     end else begin
                        // (lead*60 + mid) * word multiplier
                        job_go      = 1'b1;
                        acc_in      = fin;
                        x_in        = lead_ff;
                        y_in        = {{(rsn_pkg::MUL_W-rsn_pkg::P2_W){1'b0}},
                                       rsn_pkg::SECS_PER_MIN};
                        p2_y_in     = {{(rsn_pkg::P2_W-rsn_pkg::WORD_W){1'b0}},
                                       wmul(first, word_ff)};
                        p2_chain_in = 1'b0;
                        phase_in    = PH_DONE;
                     end
                  end else begin
                     if (ec == rsn_pkg::CH_NUL) begin
                        if (digits_ff || field_len_ff == 2'd0) begin
                           // trail + mid*60 + lead*3600
                           job_go      = 1'b1;
                           acc_in      = fin;
                           x_in        = mid_ff;
                           y_in        = {{(rsn_pkg::MUL_W-rsn_pkg::P2_W){1'b0}},
                                          rsn_pkg::SECS_PER_MIN};
                           p2_y_in     = rsn_pkg::SECS_PER_HOUR;
                           p2_chain_in = 1'b1;
                        end else begin
                           lead_in = unspec_ff;
                        end
                        phase_in = PH_DONE;
                     end else if (digits_ff || field_len_ff == 2'd0) begin
                        phase_in = PH_TRAIL_NEXT;
                     end else begin
                        job_go      = 1'b1;
                        acc_in      = '0;
                        x_in        = unspec_ff;
                        y_in        = {{(rsn_pkg::MUL_W-rsn_pkg::WORD_W){1'b0}},
                                       wmul(after_ch, word_ff)};
                        p2_y_in     = rsn_pkg::P2_ONE;
                        p2_chain_in = 1'b0;
                        phase_in    = PH_DONE;
                     end
                  end
               end

               PH_SUFFIX_NEXT: begin
                  job_go      = 1'b1;
                  job_div     = suffix_div;
                  acc_in      = '0;
                  x_in        = lead_ff;
                  y_in        = m1;
                  p2_y_in     = {{(rsn_pkg::P2_W-rsn_pkg::WORD_W){1'b0}}, m2};
                  p2_chain_in = 1'b0;
                  phase_in    = PH_DONE;
               end

               PH_TRAIL_NEXT: begin
                  job_go      = 1'b1;
                  acc_in      = '0;
                  x_in        = unspec_ff;
                  y_in        = {{(rsn_pkg::MUL_W-rsn_pkg::WORD_W){1'b0}}, wmul(ec, word_ff)};
                  p2_y_in     = rsn_pkg::P2_ONE;
                  p2_chain_in = 1'b0;
                  phase_in    = PH_DONE;
               end

               default: ;
            endcase

            pass_in = 1'b0;
            neg_in  = lead_ff[rsn_pkg::VALUE_W-1];
            if (job_go) begin
               state_in = job_div ? S_DNEG : S_MUL;
            end else if (last_ff) begin
               state_in = (phase_in == PH_DONE) ? S_OUT : S_END;
            end else begin
               state_in = S_IDLE;
            end
         end

         S_DNEG: begin
            if (neg_ff) begin
               x_in = alu_rsp.sum;
            end
            rem_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end

         S_DIV: begin
            // restoring step: shift in one dividend bit, subtract when it fits
            if (alu_rsp.carry) begin
               rem_in = alu_rsp.sum[rsn_pkg::KDIV_W-1:0];
            end else begin
               rem_in = rem_shift[rsn_pkg::KDIV_W-1:0];
            end
            x_in   = {x_ff[rsn_pkg::VALUE_W-2:0], alu_rsp.carry};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == {rsn_pkg::CNT_W{1'b1}}) begin
               state_in = S_DFIX;
            end
         end

         S_DFIX: begin
            if (neg_ff) begin
               x_in = alu_rsp.sum;
            end
            state_in = S_MUL;
         end

         S_MUL: begin
            if (y_ff == '0) begin
               if (!pass_ff) begin
                  pass_in = 1'b1;
                  y_in    = {{(rsn_pkg::MUL_W-rsn_pkg::P2_W){1'b0}}, p2_y_ff};
                  if (p2_chain_ff) begin
                     x_in = lead_ff;
                  end else begin
                     x_in   = acc_ff;
                     acc_in = '0;
                  end
               end else begin
                  pass_in  = 1'b0;
                  lead_in  = acc_ff;
                  state_in = last_ff ? S_OUT : S_IDLE;
               end
            end else begin
               if (y_ff[0]) begin
                  acc_in = alu_rsp.sum;
               end
               x_in = {x_ff[rsn_pkg::VALUE_W-2:0], 1'b0};
               y_in = {1'b0, y_ff[rsn_pkg::MUL_W-1:1]};
            end
         end

         S_OUT: begin
            // hold until the result register is free
            if (!out_valid_ff || rsp_ch.ready) begin
               out_valid_in = 1'b1;
               out_value_in = lead_ff;
               string_clear = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      if (string_clear) begin
         phase_in = PH_FIRST;
         lead_in  = '0;
         mid_in   = '0;
         stop_in  = rsn_pkg::CH_NUL;
      end
      if (field_clear || string_clear) begin
         mag_in       = '0;
         sign_in      = 1'b0;
         digits_in    = 1'b0;
         open_in      = 1'b0;
         field_len_in = 2'd0;
         fsc_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_FIRST;
         sign_ff      <= 1'b0;
         digits_ff    <= 1'b0;
         open_ff      <= 1'b0;
         field_len_ff <= 2'd0;
         fsc_ff       <= '0;
         mag_ff       <= '0;
         lead_ff      <= '0;
         mid_ff       <= '0;
         stop_ff      <= rsn_pkg::CH_NUL;
         pass_ff      <= 1'b0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
         mega_ff      <= rsn_pkg::MEGA_RST;
         giga_ff      <= rsn_pkg::GIGA_RST;
         tera_ff      <= rsn_pkg::TERA_RST;
         kdiv_ff      <= rsn_pkg::KDIV_RST;
         word_ff      <= rsn_pkg::WORD_RST;
         unspec_ff    <= rsn_pkg::UNSPEC_RST;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         sign_ff      <= sign_in;
         digits_ff    <= digits_in;
         open_ff      <= open_in;
         field_len_ff <= field_len_in;
         fsc_ff       <= fsc_in;
         mag_ff       <= mag_in;
         lead_ff      <= lead_in;
         mid_ff       <= mid_in;
         stop_ff      <= stop_in;
         pass_ff      <= pass_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
         mega_ff      <= mega_in;
         giga_ff      <= giga_in;
         tera_ff      <= tera_in;
         kdiv_ff      <= kdiv_in;
         word_ff      <= word_in;
         unspec_ff    <= unspec_in;
      end
      char_ff      <= char_in;
      last_ff      <= last_in;
      acc_ff       <= acc_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      p2_y_ff      <= p2_y_in;
      p2_chain_ff  <= p2_chain_in;
      neg_ff       <= neg_in;
      rem_ff       <= rem_in;
      out_value_ff <= out_value_in;
   end

endmodule

`default_nettype wire
